// ----- hw/rtl/ictl_pkg.sv -----
// Shared types and constants for the idle connection timeout list.
`timescale 1ns / 1ps
`default_nettype none
package ictl_pkg;

	localparam int TIME_W       = 48;
	localparam int ID_W         = 5;
	localparam int CNT_W        = 6;
	localparam int RESULT_LIMIT = 32;

	localparam logic [TIME_W-1:0] IDLE_RESET = 48'd10000000;

	localparam logic [1:0] CMD_CONNECT    = 2'd0;
	localparam logic [1:0] CMD_ACTIVITY   = 2'd1;
	localparam logic [1:0] CMD_DISCONNECT = 2'd2;
	localparam logic [1:0] CMD_TICK       = 2'd3;

	// datapath micro-operations, one per cycle
	typedef enum logic [3:0] {
		OP_NONE,
		OP_CAPTURE,
		OP_READ_ID,
		OP_APPEND_A,
		OP_APPEND_B,
		OP_UNLINK,
		OP_EMIT_CMD,
		OP_READ_CUR,
		OP_EVAL,
		OP_REPORT,
		OP_EMIT_END
	} op_t;

	typedef struct packed {
		op_t  op;
		logic err;
	} dp_cmd_t;

	typedef struct packed {
		logic is_tick;
		logic is_connect;
		logic is_activity;
		logic cmd_err;
		logic cur_null;
		logic walk_full;
		logic future;
		logic stale;
		logic pending;
		logic out_free;
	} dp_status_t;

endpackage
`default_nettype wire

// ----- hw/rtl/idle_connection_timeout_list.sv -----
// Idle connection timeout list: keeps connections ordered by last activity.
// Usage:
//   Input channel (in_valid/in_ready) carries command, conn_id and now_time.
//   Output channel (out_valid/out_ready) returns target_id, shutdown, error,
//   last_result and active_count; last_result marks the final transaction
//   caused by one input transaction.
//   cfg_we/cfg_wdata write idle_limit; write only while idle.
// Sequencing (one input transaction at a time): a command error is reported
//   directly; connect appends, disconnect unlinks, activity unlinks and
//   re-appends. A tick walks from the head; each visited entry takes a
//   linked-list memory read, then an age compare, and each stale entry
//   adds a shutdown report. The walk ends at a fresh entry, at the list
//   end, or at the cap of 32 reports per tick. Link and timestamp memories
//   have one read port each.
// Reset: all slots unlisted, head/tail null, idle_limit = 10 s; no
//   memory clearing pass is needed, the block is ready right after reset.
// Stall: a result waits in the output register; the next input transaction
//   is taken meanwhile, and the block holds only when a further result is due.
`timescale 1ns / 1ps
`default_nettype none
module idle_connection_timeout_list #(
	parameter int MAX_CONNECTIONS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [ictl_pkg::TIME_W-1:0] cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  command,
	input  logic [ictl_pkg::ID_W-1:0]   conn_id,
	input  logic [ictl_pkg::TIME_W-1:0] now_time,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [ictl_pkg::ID_W-1:0]   target_id,
	output logic                        shutdown,
	output logic                        error,
	output logic                        last_result,
	output logic [ictl_pkg::CNT_W-1:0]  active_count
);
	import ictl_pkg::*;

	dp_cmd_t    dp_cmd;
	dp_status_t dp_status;

	ictl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (dp_status),
		.cmd      (dp_cmd)
	);

	ictl_dp #(.MAX_CONNECTIONS(MAX_CONNECTIONS)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.command      (command),
		.conn_id      (conn_id),
		.now_time     (now_time),
		.cmd          (dp_cmd),
		.status       (dp_status),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.target_id    (target_id),
		.shutdown     (shutdown),
		.error        (error),
		.last_result  (last_result),
		.active_count (active_count)
	);

endmodule
`default_nettype wire

// ----- hw/rtl/ictl_ram.sv -----
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
`default_nettype none
module ictl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ----- hw/rtl/ictl_ctrl.sv -----
// Controller state machine sequencing list updates and the tick walk.
`timescale 1ns / 1ps
`default_nettype none
module ictl_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ictl_pkg::dp_status_t status,
	output ictl_pkg::dp_cmd_t    cmd
);
	import ictl_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_UNL_RD,
		S_UNL_WR,
		S_APP_A,
		S_APP_B,
		S_EMIT,
		S_WALK,
		S_EVAL,
		S_REPORT,
		S_END
	} state_t;

	state_t state_q, state_d;
	logic   err_q, err_d;

	always_comb begin
		state_d  = state_q;
		err_d    = err_q;
		cmd.op   = OP_NONE;
		cmd.err  = err_q;
		in_ready = (state_q == S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_CAPTURE;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if (status.is_tick) begin
					state_d = S_WALK;
				end else if (status.cmd_err) begin
					err_d   = 1'b1;
					state_d = S_EMIT;
				end else begin
					err_d   = 1'b0;
					state_d = status.is_connect ? S_APP_A : S_UNL_RD;
				end
			end
			S_UNL_RD: begin
				cmd.op  = OP_READ_ID;
				state_d = S_UNL_WR;
			end
			S_UNL_WR: begin
				cmd.op  = OP_UNLINK;
				state_d = status.is_activity ? S_APP_A : S_EMIT;
			end
			S_APP_A: begin
				cmd.op  = OP_APPEND_A;
				state_d = S_APP_B;
			end
			S_APP_B: begin
				cmd.op  = OP_APPEND_B;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (status.out_free) begin
					cmd.op  = OP_EMIT_CMD;
					state_d = S_IDLE;
				end
			end
			S_WALK: begin
				if (status.cur_null || status.walk_full) begin
					state_d = S_END;
				end else begin
					cmd.op  = OP_READ_CUR;
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.op = OP_EVAL;
				if (status.future) begin
					state_d = S_WALK;
				end else if (status.stale) begin
					state_d = S_REPORT;
				end else begin
					state_d = S_END;
				end
			end
			S_REPORT: begin
				// a held report goes out only once the next one is known
				if (!status.pending || status.out_free) begin
					cmd.op  = OP_REPORT;
					state_d = S_WALK;
				end
			end
			S_END: begin
				if (status.out_free) begin
					cmd.op  = OP_EMIT_END;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			err_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			err_q   <= err_d;
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/ictl_dp.sv -----
// Datapath: link memories, list registers, age compare and result register.
`timescale 1ns / 1ps
`default_nettype none
module ictl_dp #(
	parameter int MAX_CONNECTIONS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [ictl_pkg::TIME_W-1:0] cfg_wdata,
	input  logic [1:0]                  command,
	input  logic [ictl_pkg::ID_W-1:0]   conn_id,
	input  logic [ictl_pkg::TIME_W-1:0] now_time,
	input  ictl_pkg::dp_cmd_t           cmd,
	output ictl_pkg::dp_status_t        status,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [ictl_pkg::ID_W-1:0]   target_id,
	output logic                        shutdown,
	output logic                        error,
	output logic                        last_result,
	output logic [ictl_pkg::CNT_W-1:0]  active_count
);
	import ictl_pkg::*;

	localparam int IW = $clog2(MAX_CONNECTIONS);
	localparam int LW = $clog2(MAX_CONNECTIONS + 1);
	localparam logic [LW-1:0] NULL_LINK = LW'(MAX_CONNECTIONS);

	logic [TIME_W-1:0]          idle_limit_q;
	logic [1:0]                 cmd_q;
	logic [ID_W-1:0]            id_q;
	logic [TIME_W-1:0]          now_q;
	logic [LW-1:0]              head_q, tail_q, cur_q, next_q;
	logic [CNT_W-1:0]           count_q, nres_q;
	logic                       pending_q;
	logic [ID_W-1:0]            pend_id_q;
	logic [MAX_CONNECTIONS-1:0] listed_q;

	logic                       out_valid_q;
	logic [ID_W-1:0]            target_q;
	logic                       shutdown_q, error_q, last_q;
	logic [CNT_W-1:0]           active_q;

	logic [IW-1:0]     id_ix;
	logic [LW-1:0]     id_link;
	logic              id_ok, id_listed;
	logic [LW-1:0]     next_rd, prev_rd;
	logic [TIME_W-1:0] seen_rd;
	logic [TIME_W:0]   age;
	logic              out_free;

	logic              nx_we, pv_we, ls_we;
	logic [IW-1:0]     nx_waddr, pv_waddr, ls_waddr, raddr;
	logic [LW-1:0]     nx_wdata, pv_wdata;
	logic [TIME_W-1:0] ls_wdata;

	logic              out_load;
	logic [ID_W-1:0]   ld_target;
	logic              ld_sd, ld_err, ld_last;

	assign id_ix     = IW'(id_q);
	assign id_link   = LW'(id_q);
	assign id_ok     = 32'(id_q) < 32'(MAX_CONNECTIONS);
	assign id_listed = id_ok && listed_q[id_ix];
	// bit TIME_W set means the stamp lies in the future
	assign age       = {1'b0, now_q} - {1'b0, seen_rd};
	assign out_free  = !out_valid_q || out_ready;

	assign status.is_tick     = (cmd_q == CMD_TICK);
	assign status.is_connect  = (cmd_q == CMD_CONNECT);
	assign status.is_activity = (cmd_q == CMD_ACTIVITY);
	assign status.cmd_err     = (cmd_q == CMD_CONNECT) ? (!id_ok || id_listed) : !id_listed;
	assign status.cur_null    = (cur_q == NULL_LINK);
	assign status.walk_full   = (nres_q == CNT_W'(RESULT_LIMIT));
	assign status.future      = age[TIME_W];
	assign status.stale       = !age[TIME_W] && (age[TIME_W-1:0] > idle_limit_q);
	assign status.pending     = pending_q;
	assign status.out_free    = out_free;

	ictl_ram #(.WIDTH(LW), .DEPTH(MAX_CONNECTIONS)) u_next_ram (
		.clk   (clk),
		.we    (nx_we),
		.waddr (nx_waddr),
		.wdata (nx_wdata),
		.raddr (raddr),
		.rdata (next_rd)
	);

	ictl_ram #(.WIDTH(LW), .DEPTH(MAX_CONNECTIONS)) u_prev_ram (
		.clk   (clk),
		.we    (pv_we),
		.waddr (pv_waddr),
		.wdata (pv_wdata),
		.raddr (raddr),
		.rdata (prev_rd)
	);

	ictl_ram #(.WIDTH(TIME_W), .DEPTH(MAX_CONNECTIONS)) u_seen_ram (
		.clk   (clk),
		.we    (ls_we),
		.waddr (ls_waddr),
		.wdata (ls_wdata),
		.raddr (raddr),
		.rdata (seen_rd)
	);

	always_comb begin
		raddr    = (cmd.op == OP_READ_CUR) ? IW'(cur_q) : id_ix;
		nx_we    = 1'b0;
		nx_waddr = id_ix;
		nx_wdata = NULL_LINK;
		pv_we    = 1'b0;
		pv_waddr = id_ix;
		pv_wdata = tail_q;
		ls_we    = 1'b0;
		ls_waddr = id_ix;
		ls_wdata = now_q;
		case (cmd.op)
			OP_APPEND_A: begin
				ls_we = 1'b1;
				pv_we = 1'b1;
				nx_we = 1'b1;
			end
			OP_APPEND_B: begin
				nx_we    = (tail_q != NULL_LINK);
				nx_waddr = IW'(tail_q);
				nx_wdata = id_link;
			end
			OP_UNLINK: begin
				nx_we    = (prev_rd != NULL_LINK);
				nx_waddr = IW'(prev_rd);
				nx_wdata = next_rd;
				pv_we    = (next_rd != NULL_LINK);
				pv_waddr = IW'(next_rd);
				pv_wdata = prev_rd;
			end
			OP_EVAL: begin
				// clock stepped back: restamp
				ls_we    = age[TIME_W];
				ls_waddr = IW'(cur_q);
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		out_load  = 1'b0;
		ld_target = id_q;
		ld_sd     = 1'b0;
		ld_err    = 1'b0;
		ld_last   = 1'b1;
		case (cmd.op)
			OP_EMIT_CMD: begin
				out_load = 1'b1;
				ld_err   = cmd.err;
			end
			OP_REPORT: begin
				out_load  = pending_q;
				ld_target = pend_id_q;
				ld_sd     = 1'b1;
				ld_last   = 1'b0;
			end
			OP_EMIT_END: begin
				out_load  = 1'b1;
				ld_target = pending_q ? pend_id_q : '0;
				ld_sd     = pending_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_limit_q <= IDLE_RESET;
			head_q       <= NULL_LINK;
			tail_q       <= NULL_LINK;
			count_q      <= '0;
			listed_q     <= '0;
			nres_q       <= '0;
			pending_q    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				idle_limit_q <= cfg_wdata;
			end
			case (cmd.op)
				OP_CAPTURE: begin
					nres_q    <= '0;
					pending_q <= 1'b0;
				end
				OP_APPEND_B: begin
					if (tail_q == NULL_LINK) begin
						head_q <= id_link;
					end
					tail_q <= id_link;
					if (cmd_q == CMD_CONNECT) begin
						listed_q[id_ix] <= 1'b1;
						count_q         <= count_q + CNT_W'(1);
					end
				end
				OP_UNLINK: begin
					if (prev_rd == NULL_LINK) begin
						head_q <= next_rd;
					end
					if (next_rd == NULL_LINK) begin
						tail_q <= prev_rd;
					end
					if (cmd_q == CMD_DISCONNECT) begin
						listed_q[id_ix] <= 1'b0;
						count_q         <= count_q - CNT_W'(1);
					end
				end
				OP_REPORT: begin
					pending_q <= 1'b1;
					nres_q    <= nres_q + CNT_W'(1);
				end
				default: begin
				end
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_CAPTURE: begin
				cmd_q <= command;
				id_q  <= conn_id;
				now_q <= now_time;
				cur_q <= head_q;
			end
			OP_EVAL: begin
				next_q <= next_rd;
				if (age[TIME_W]) begin
					cur_q <= next_rd;
				end
			end
			OP_REPORT: begin
				pend_id_q <= ID_W'(cur_q);
				cur_q     <= next_q;
			end
			default: begin
			end
		endcase
		if (out_load) begin
			target_q   <= ld_target;
			shutdown_q <= ld_sd;
			error_q    <= ld_err;
			last_q     <= ld_last;
			active_q   <= count_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign target_id    = target_q;
	assign shutdown     = shutdown_q;
	assign error        = error_q;
	assign last_result  = last_q;
	assign active_count = active_q;

	a_count_matches_listed: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(listed_q) == int'(count_q))
		else $error("listed bits and count disagree");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= 32'(MAX_CONNECTIONS))
		else $error("count above capacity");

	a_head_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_CAPTURE) |-> ((head_q == NULL_LINK) == (count_q == '0)))
		else $error("head pointer inconsistent with count");

	a_tail_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_CAPTURE) |-> ((tail_q == NULL_LINK) == (count_q == '0)))
		else $error("tail pointer inconsistent with count");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free)
		else $error("result register overwritten before transaction");

endmodule
`default_nettype wire
